/* hw/rtl/lru_key_value_cache_unit_assert.svh */
// Assertion macros for the LRU key-value cache checker.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define LKVC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LKVC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/lkvc_pkg.sv */
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
  localparam logic                     OP_GET     = 1'b0;
  localparam logic                     OP_SET     = 1'b1;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] SET_VALUE  = 32'sd0;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic promote;
    logic wr_key;
    logic wr_val;
    logic set_valid;
    logic result_valid;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_set;
    logic hit;
    logic evict;
  } dp_stat_t;

endpackage

/* hw/rtl/lkvc_ctrl.sv */
`timescale 1ns / 1ps
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // get miss leaves the ages alone; everything else promotes its slot
        cmd.promote      = stat.hit || stat.is_set;
        cmd.wr_val       = stat.is_set;
        cmd.wr_key       = stat.is_set && !stat.hit;
        cmd.set_valid    = stat.is_set && !stat.hit && !stat.evict;
        cmd.result_valid = 1'b1;
        state_next       = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* hw/rtl/lkvc_dpath.sv */
`timescale 1ns / 1ps
module lkvc_dpath
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             capacity_we,
  input  logic [CAP_W-1:0] capacity_wdata,
  input  req_t             request,
  input  ctl_cmd_t         cmd,
  output dp_stat_t         stat,
  output rsp_t             result,
  output logic             done
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  req_t                     req_q;
  logic [CAP_W-1:0]         capacity;
  logic signed [DATA_W-1:0] keys [ENTRIES];
  logic signed [DATA_W-1:0] vals [ENTRIES];
  logic [IW-1:0]            rank [ENTRIES];
  logic [ENTRIES-1:0]       valid;
  logic [CW-1:0]            occ;
  logic [IW-1:0]            slot;
  logic [CW-1:0]            srank;
  logic                     hit_q;
  logic                     evict_q;
  logic signed [DATA_W-1:0] rd_data;

  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] victim;
  logic [IW-1:0]      match_idx;
  logic [IW-1:0]      victim_idx;
  logic [IW-1:0]      match_rank;
  logic               any_hit;
  logic               evict_need;
  logic [CW-1:0]      occ_m1;
  logic [CMPW-1:0]    cap_ext;
  logic [CMPW-1:0]    eff_cap;
  logic [IW-1:0]      slot_next;
  logic [CW-1:0]      srank_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (capacity_we) begin
      capacity <= capacity_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= request;
    end
  end

  // Parallel key compare; valid entries occupy slots 0..occ-1 and their
  // ranks form a permutation of 0..occ-1, so the victim is rank occ-1.
  assign occ_m1 = occ - CW'(1);

  always_comb begin
    match_idx  = '0;
    victim_idx = '0;
    match_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = valid[i] && (keys[i] == req_q.key);
      victim[i] = valid[i] && (CW'(rank[i]) == occ_m1);
      if (match[i]) begin
        match_idx  = match_idx | IW'(i);
        match_rank = match_rank | rank[i];
      end
      if (victim[i]) begin
        victim_idx = victim_idx | IW'(i);
      end
    end
  end

  assign any_hit = |match;
  assign cap_ext = CMPW'(capacity);

  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign evict_need = (req_q.opcode == OP_SET) && !any_hit && (CMPW'(occ) >= eff_cap);

  always_comb begin
    if (any_hit) begin
      slot_next  = match_idx;
      srank_next = CW'(match_rank);
    end else if (evict_need) begin
      slot_next  = victim_idx;
      srank_next = occ_m1;
    end else begin
      slot_next  = occ[IW-1:0];
      srank_next = occ;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      slot    <= slot_next;
      srank   <= srank_next;
      hit_q   <= any_hit;
      evict_q <= evict_need;
    end
  end

  // Value store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_val) begin
      vals[slot] <= req_q.value;
    end
    if (cmd.lookup) begin
      rd_data <= vals[slot_next];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key) begin
      keys[slot] <= req_q.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cmd.promote) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IW'(i) == slot) begin
            rank[i] <= '0;
          end else if (valid[i] && (CW'(rank[i]) < srank)) begin
            rank[i] <= rank[i] + IW'(1);
          end
        end
      end
      if (cmd.set_valid) begin
        valid[slot] <= 1'b1;
        occ         <= occ + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_valid) begin
      result.hit <= hit_q;
      if (req_q.opcode == OP_SET) begin
        result.read_value <= SET_VALUE;
      end else if (hit_q) begin
        result.read_value <= rd_data;
      end else begin
        result.read_value <= MISS_VALUE;
      end
    end
  end

  assign stat.is_set = (req_q.opcode == OP_SET);
  assign stat.hit    = hit_q;
  assign stat.evict  = evict_q;

endmodule

/* hw/rtl/lru_key_value_cache_unit.sv */
`timescale 1ns / 1ps
// Channel      Ports                          Beat taken when
// request      start, busy, request           start high and busy low
// result       done, result                   done high (one cycle, no stall)
// capacity     capacity_we, capacity_wdata    capacity_we high
//
// Sequence: a request beat passes through capture, parallel lookup with
//   registered value read, and commit before its result; busy is high for
//   lookup and commit, so the next request waits until the block is idle.
//   The value store's single registered read port sets the lookup stage.
// Reset: synchronous rst clears valid marks, ages, occupancy and the FSM;
//   capacity returns to 16. No clearing pass is needed.
// Stalls: the result side cannot stall; done pulses for exactly one cycle
//   and a new request may be taken in that same cycle.
module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             done,
  output rsp_t             result,
  input  logic             capacity_we,
  input  logic [CAP_W-1:0] capacity_wdata
);

  // Controller drives commands per phase; datapath reports the lookup
  // outcome (hit, eviction needed, operation kind) back for the commit.
  ctl_cmd_t cmd;
  dp_stat_t stat;

  lkvc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Datapath: key lanes with per-lane compare, age ranks, valid marks,
  // occupancy, capacity register and the value store.
  lkvc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .request        (request),
    .cmd            (cmd),
    .stat           (stat),
    .result         (result),
    .done           (done)
  );

endmodule

/* hw/rtl/lkvc_checker.sv */
`timescale 1ns / 1ps
`include "lru_key_value_cache_unit_assert.svh"
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t result
);

  `LKVC_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted beat did not raise busy")
  `LKVC_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result beat while still busy")
  `LKVC_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe longer than one cycle")
  `LKVC_ASSERT_NOW(a_done_after_busy, clk, rst, done, $past(busy), "result beat without preceding work")
  `LKVC_ASSERT_NOW(a_miss_value, clk, rst, done && !result.hit, (result.read_value == MISS_VALUE) || (result.read_value == SET_VALUE), "miss result carries a stored value")

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import lkvc_pkg::*;

  localparam int ENTRIES          = ENTRIES_DEFAULT;
  // Acceptance to result strobe, per the block's pipeline.
  localparam int RESULT_LATENCY   = 3;
  localparam int SETTLE_CYCLES    = RESULT_LATENCY + 2;
  localparam int DRAIN_LIMIT      = 200;
  localparam int KEY_POOL_MAX     = 24;
  localparam int ITEMS_PER_PHASE  = 100;
  localparam int PHASE_COUNT      = 16;
  // Slowest correct run is well under 100 us; allow many times that.
  localparam int RUN_LIMIT_NS     = 2_000_000;

  // Shadow LRU cache: tracks keys, values, recency ranks and occupancy,
  // and queues the lookup response that each accepted beat must produce.
  class lru_shadow;
    logic [CAP_W-1:0]         capacity;
    logic signed [DATA_W-1:0] keys   [ENTRIES];
    logic signed [DATA_W-1:0] values [ENTRIES];
    bit                       valid  [ENTRIES];
    int unsigned              rank   [ENTRIES];
    int unsigned              occupied;
    rsp_t                     pending_rsp[$];
    int                       errors;
    int                       lookups_hit;
    int                       lookups_missed;
    int                       evictions;
    int                       responses_seen;

    function new();
      capacity = CAP_RESET;
      occupied = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] = 1'b0;
        rank[i]  = 0;
        keys[i]  = '0;
        values[i] = '0;
      end
      errors = 0;
      lookups_hit = 0;
      lookups_missed = 0;
      evictions = 0;
      responses_seen = 0;
    endfunction

    // Zero acts as one; anything above the array size acts as the array size.
    function int unsigned usable_entries();
      int unsigned c;
      c = capacity;
      if (c == 0) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
    endfunction

    // Make slot s most recent; age every valid entry ranked above it.
    function void make_recent(int s, int unsigned s_rank);
      for (int i = 0; i < ENTRIES; i++) begin
        if (i != s && valid[i] && rank[i] < s_rank) rank[i] = rank[i] + 1;
      end
      rank[s] = 0;
    endfunction

    function void note_request(req_t r);
      int   slot;
      rsp_t want;
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && valid[i] && keys[i] == r.key) slot = i;
      end
      if (slot >= 0) lookups_hit++;
      else lookups_missed++;
      if (r.opcode == OP_GET) begin
        if (slot >= 0) begin
          want.hit        = 1'b1;
          want.read_value = values[slot];
          make_recent(slot, rank[slot]);
        end else begin
          want.hit        = 1'b0;
          want.read_value = MISS_VALUE;
        end
      end else begin
        want.hit        = (slot >= 0);
        want.read_value = SET_VALUE;
        if (slot >= 0) begin
          values[slot] = r.value;
          make_recent(slot, rank[slot]);
        end else if (occupied >= usable_entries() && occupied > 0) begin
          // Full (or over the lowered limit): reuse the oldest slot.
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid[i] && (slot < 0 || rank[i] > rank[slot])) slot = i;
          end
          keys[slot]   = r.key;
          values[slot] = r.value;
          make_recent(slot, rank[slot]);
          evictions++;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !valid[i]) slot = i;
          end
          if (slot >= 0) begin
            valid[slot]  = 1'b1;
            keys[slot]   = r.key;
            values[slot] = r.value;
            make_recent(slot, occupied);
            occupied++;
          end
        end
      end
      pending_rsp.push_back(want);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      responses_seen++;
      if (pending_rsp.size() == 0) begin
        report($sformatf("response with nothing pending: hit=%0b read_value=%0d",
                         got.hit, got.read_value));
        return;
      end
      want = pending_rsp.pop_front();
      if (got.hit !== want.hit)
        report($sformatf("response %0d hit: got %0b want %0b",
                         responses_seen, got.hit, want.hit));
      if (got.read_value !== want.read_value)
        report($sformatf("response %0d read_value: got %0d want %0d",
                         responses_seen, got.read_value, want.read_value));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  req_t             request = '0;
  logic             done;
  rsp_t             result;
  logic             capacity_we = 1'b0;
  logic [CAP_W-1:0] capacity_wdata = '0;

  lru_shadow                shadow = new();
  logic signed [DATA_W-1:0] key_pool [KEY_POOL_MAX];
  int                       pool_size;
  int                       requests_sent = 0;
  int                       capacity_writes = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lru_key_value_cache_unit #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .capacity_we   (capacity_we),
    .capacity_wdata(capacity_wdata)
  );

  // Results cannot be held off: take every strobe at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) shadow.check_result(result);
  end

  // Present one beat from a falling edge and hold it until the block takes it;
  // return at the following falling edge with start still high, so a back-to-back
  // beat is simply overwritten there.
  task automatic send_request(input req_t r);
    start   = 1'b1;
    request = r;
    do @(posedge clk); while (busy);
    shadow.note_request(r);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic send_fields(input logic op, input logic signed [DATA_W-1:0] k,
                             input logic signed [DATA_W-1:0] v);
    req_t r;
    r.opcode = op;
    r.key    = k;
    r.value  = v;
    send_request(r);
  endtask

  task automatic pause(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Drop start and hold off until every pending response has come back,
  // then let the pipeline settle. A lost response ends the wait at a bound.
  task automatic drain();
    int waited;
    waited = 0;
    start = 1'b0;
    while (shadow.pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the capacity register only with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain();
    capacity_we    = 1'b1;
    capacity_wdata = cap;
    @(negedge clk);
    capacity_we    = 1'b0;
    shadow.capacity = cap;
    capacity_writes++;
  endtask

  // Keep about half of the old keys so residents left over from a larger
  // capacity still get hit; size the pool just above the usable entries so
  // lookups both hit and miss.
  task automatic refresh_key_pool();
    pool_size = shadow.usable_entries() + $urandom_range(1, 6);
    if (pool_size > KEY_POOL_MAX) pool_size = KEY_POOL_MAX;
    for (int i = 0; i < KEY_POOL_MAX; i++) begin
      if ($urandom_range(0, 1) == 1) key_pool[i] = $urandom;
    end
  endtask

  function automatic req_t random_request();
    req_t r;
    r.opcode = ($urandom_range(0, 99) < 45) ? OP_SET : OP_GET;
    if ($urandom_range(0, 9) == 0) r.key = $urandom;
    else r.key = key_pool[$urandom_range(0, pool_size - 1)];
    r.value = $urandom;
    return r;
  endfunction

  // Capacity schedule: extremes (0 acts as 1, 31 acts as 16) plus several
  // drops below the current occupancy so the over-limit eviction path runs.
  logic [CAP_W-1:0] phase_cap [PHASE_COUNT] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd16, 5'd3,
    5'd12, 5'd2, 5'd8, 5'd16, 5'd4, 5'd31, 5'd1, 5'd10
  };

  initial begin
    int items_left;
    int burst;
    bit steady;
    for (int i = 0; i < KEY_POOL_MAX; i++) key_pool[i] = $urandom;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: lookup on an empty cache at the reset capacity.
    send_fields(OP_GET, 32'sd0, 32'sd0);
    write_capacity(5'd3);
    // Fill with the key extremes and their mirrored values.
    send_fields(OP_SET, 32'sh8000_0000, 32'sh7fff_ffff);
    send_fields(OP_SET, 32'sh7fff_ffff, 32'sh8000_0000);
    send_fields(OP_SET, -32'sd1, -32'sd1);
    // Hit each one; the value field must be ignored on a get.
    send_fields(OP_GET, 32'sh8000_0000, 32'sh5555_5555);
    send_fields(OP_GET, 32'sh7fff_ffff, 32'shaaaa_aaaa);
    send_fields(OP_GET, -32'sd1, 32'sd0);
    // Overwrite in place, then read it back.
    send_fields(OP_SET, 32'sh7fff_ffff, 32'sh1234_5678);
    send_fields(OP_GET, 32'sh7fff_ffff, 32'sd0);
    // Miss while full: evicts the least recent (the most negative key).
    send_fields(OP_SET, 32'sd0, 32'sd0);
    send_fields(OP_GET, 32'sh8000_0000, 32'sd0);
    send_fields(OP_GET, -32'sd1, 32'sd0);
    send_fields(OP_GET, 32'sd0, 32'sd0);
    // Lower below occupancy: each missing set replaces exactly one entry.
    write_capacity(5'd1);
    send_fields(OP_SET, 32'sd7, 32'sd70);
    send_fields(OP_SET, 32'sd8, 32'sd80);
    send_fields(OP_GET, 32'sd7, 32'sd0);
    send_fields(OP_GET, 32'sd8, 32'sd0);
    send_fields(OP_GET, 32'sd0, 32'sd0);
    send_fields(OP_GET, 32'sh7fff_ffff, 32'sd0);

    // Random phases: bursts of random length separated by random gaps,
    // with some phases streaming back to back.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(phase_cap[p]);
      refresh_key_pool();
      steady = (p % 4 == 2);
      items_left = ITEMS_PER_PHASE;
      while (items_left > 0) begin
        burst = $urandom_range(1, 20);
        while (burst > 0 && items_left > 0) begin
          send_request(random_request());
          burst--;
          items_left--;
        end
        if ($urandom_range(0, 39) == 0) drain();
        else if (!steady) begin
          burst = $urandom_range(0, 8);
          if (burst > 0) pause(burst);
        end
      end
    end

    drain();
    while (shadow.pending_rsp.size() != 0) begin
      shadow.report("response never arrived");
      void'(shadow.pending_rsp.pop_front());
    end

    $display("run covered %0d requests and %0d capacity writes: %0d key hits, %0d misses,",
             requests_sent, capacity_writes, shadow.lookups_hit, shadow.lookups_missed);
    $display("  %0d evictions, %0d responses checked, %0d mismatches",
             shadow.evictions, shadow.responses_seen, shadow.errors);
    if (shadow.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: end a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout after %0d ns", RUN_LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ctrl.sv
hw/rtl/lkvc_dpath.sv
hw/rtl/lru_key_value_cache_unit.sv
hw/rtl/lkvc_checker.sv
verif/testbench.sv
